// ===== design/mafm_pkg.sv =====
// mafm_pkg: shared types and constants for the memory address field mapper
// holds the config, layout and result structs, register indexes and mode codes
// no dependencies

package mafm_pkg;

   localparam int ADDR_W   = 64;
   localparam int OFF_W    = 7;    // largest field offset is well below 128
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   localparam int VAULT_W  = 10;
   localparam int BANK_W   = 4;
   localparam int GROUP_W  = 4;
   localparam int ROW_W    = 20;
   localparam int COL_W    = 12;
   localparam int RESULT_W = VAULT_W + BANK_W + GROUP_W + ROW_W + COL_W;
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TX    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VAULT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BANK  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ROW   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COL   = 3'd7;

   // field orders, lowest field first after the low column bits
   localparam logic [2:0] MODE_VA_BA_BG_CH_RO = 3'd0;
   localparam logic [2:0] MODE_CH_VA_BA_BG_RO = 3'd1;
   localparam logic [2:0] MODE_VA_CH_BA_BG_RO = 3'd2;
   localparam logic [2:0] MODE_VA_BG_BA_CH_RO = 3'd3;
   localparam logic [2:0] MODE_BA_BG_CH_RO_VA = 3'd4;

   typedef struct packed {
      logic [2:0] mode;
      logic [3:0] tx_bits;
      logic [3:0] block_bits;
      logic [3:0] vault_w;
      logic [2:0] bank_w;
      logic [2:0] group_w;
      logic [4:0] row_w;
      logic [3:0] col_w;
   } cfg_type;

   typedef struct packed {
      logic [OFF_W-1:0] col_low_off;
      logic [3:0]       col_low_w;
      logic [OFF_W-1:0] col_high_off;
      logic [3:0]       col_high_w;
      logic [OFF_W-1:0] vault_off;
      logic [OFF_W-1:0] bank_off;
      logic [OFF_W-1:0] group_off;
      logic [OFF_W-1:0] row_off;
   } layout_type;

   // first field in the highest bits, last field in the lowest
   typedef struct packed {
      logic [COL_W-1:0]   column_index;
      logic [ROW_W-1:0]   row_index;
      logic [GROUP_W-1:0] bankgroup_index;
      logic [BANK_W-1:0]  bank_index;
      logic [VAULT_W-1:0] vault_index;
   } result_type;

endpackage

// ===== design/mafm_csr.sv =====
// mafm_csr: configuration registers of the address field mapper
// depends on mafm_pkg for the config struct and register indexes

module mafm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mafm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mafm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mafm_pkg::cfg_type                   cfg
);

   mafm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            mafm_pkg::REG_MODE:  cfg_in.mode       = csr_wdata[2:0];
            mafm_pkg::REG_TX:    cfg_in.tx_bits    = csr_wdata[3:0];
            mafm_pkg::REG_BLOCK: cfg_in.block_bits = csr_wdata[3:0];
            mafm_pkg::REG_VAULT: cfg_in.vault_w    = csr_wdata[3:0];
            mafm_pkg::REG_BANK:  cfg_in.bank_w     = csr_wdata[2:0];
            mafm_pkg::REG_GROUP: cfg_in.group_w    = csr_wdata[2:0];
            mafm_pkg::REG_ROW:   cfg_in.row_w      = csr_wdata[4:0];
            mafm_pkg::REG_COL:   cfg_in.col_w      = csr_wdata[3:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= mafm_pkg::MODE_VA_BA_BG_CH_RO;
         cfg_ff.tx_bits    <= 4'd6;
         cfg_ff.block_bits <= 4'd7;
         cfg_ff.vault_w    <= 4'd5;
         cfg_ff.bank_w     <= 3'd2;
         cfg_ff.group_w    <= 3'd2;
         cfg_ff.row_w      <= 5'd15;
         cfg_ff.col_w      <= 4'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/mafm_layout.sv =====
// mafm_layout: turns the field widths and mapping mode into bit offsets
// depends on mafm_pkg for the config and layout structs

module mafm_layout (
   input  mafm_pkg::cfg_type    cfg,
   output mafm_pkg::layout_type layout
);

   localparam int OW = mafm_pkg::OFF_W;

   logic [3:0]    col_low_w;
   logic [3:0]    col_high_w;
   logic [OW-1:0] base;
   logic [OW-1:0] vw, bw, gw, rw, hw;

   always_comb begin
      // negative widths clamp to zero
      col_low_w  = (cfg.block_bits > cfg.tx_bits) ? (cfg.block_bits - cfg.tx_bits) : 4'd0;
      col_high_w = (cfg.col_w > col_low_w) ? (cfg.col_w - col_low_w) : 4'd0;
      base = OW'(cfg.tx_bits) + OW'(col_low_w);
      vw = OW'(cfg.vault_w);
      bw = OW'(cfg.bank_w);
      gw = OW'(cfg.group_w);
      rw = OW'(cfg.row_w);
      hw = OW'(col_high_w);

      layout.col_low_off = OW'(cfg.tx_bits);
      layout.col_low_w   = col_low_w;
      layout.col_high_w  = col_high_w;

      case (cfg.mode)
         mafm_pkg::MODE_CH_VA_BA_BG_RO: begin
            layout.col_high_off = base;
            layout.vault_off    = base + hw;
            layout.bank_off     = base + hw + vw;
            layout.group_off    = base + hw + vw + bw;
            layout.row_off      = base + hw + vw + bw + gw;
         end
         mafm_pkg::MODE_VA_CH_BA_BG_RO: begin
            layout.vault_off    = base;
            layout.col_high_off = base + vw;
            layout.bank_off     = base + vw + hw;
            layout.group_off    = base + vw + hw + bw;
            layout.row_off      = base + vw + hw + bw + gw;
         end
         mafm_pkg::MODE_VA_BG_BA_CH_RO: begin
            layout.vault_off    = base;
            layout.group_off    = base + vw;
            layout.bank_off     = base + vw + gw;
            layout.col_high_off = base + vw + gw + bw;
            layout.row_off      = base + vw + gw + bw + hw;
         end
         mafm_pkg::MODE_BA_BG_CH_RO_VA: begin
            layout.bank_off     = base;
            layout.group_off    = base + bw;
            layout.col_high_off = base + bw + gw;
            layout.row_off      = base + bw + gw + hw;
            layout.vault_off    = base + bw + gw + hw + rw;
         end
         default: begin
            // unused mode codes fall back to the first order
            layout.vault_off    = base;
            layout.bank_off     = base + vw;
            layout.group_off    = base + vw + bw;
            layout.col_high_off = base + vw + bw + gw;
            layout.row_off      = base + vw + bw + gw + hw;
         end
      endcase
   end

endmodule

// ===== design/mafm_slice.sv =====
// mafm_slice: cuts the address into fields at the offsets from mafm_layout
// depends on mafm_pkg for the layout and result structs

module mafm_slice (
   input  logic [mafm_pkg::ADDR_W-1:0] phys_address,
   input  mafm_pkg::cfg_type           cfg,
   input  mafm_pkg::layout_type        layout,
   output mafm_pkg::result_type        result
);

   localparam int AW = mafm_pkg::ADDR_W;
   localparam int CW = mafm_pkg::COL_W;

   // offsets of 64 or more shift everything out, leaving zero
   logic [AW-1:0] sh_vault, sh_bank, sh_group, sh_row, sh_clow, sh_chigh;
   logic [CW-1:0] col_low, col_high;

   always_comb begin
      sh_vault = phys_address >> layout.vault_off;
      sh_bank  = phys_address >> layout.bank_off;
      sh_group = phys_address >> layout.group_off;
      sh_row   = phys_address >> layout.row_off;
      sh_clow  = phys_address >> layout.col_low_off;
      sh_chigh = phys_address >> layout.col_high_off;

      result.vault_index = sh_vault[mafm_pkg::VAULT_W-1:0]
                         & ~({mafm_pkg::VAULT_W{1'b1}} << cfg.vault_w);
      result.bank_index  = sh_bank[mafm_pkg::BANK_W-1:0]
                         & ~({mafm_pkg::BANK_W{1'b1}} << cfg.bank_w);
      result.bankgroup_index = sh_group[mafm_pkg::GROUP_W-1:0]
                         & ~({mafm_pkg::GROUP_W{1'b1}} << cfg.group_w);
      result.row_index   = sh_row[mafm_pkg::ROW_W-1:0]
                         & ~({mafm_pkg::ROW_W{1'b1}} << cfg.row_w);

      col_low  = sh_clow[CW-1:0]  & ~({CW{1'b1}} << layout.col_low_w);
      col_high = sh_chigh[CW-1:0] & ~({CW{1'b1}} << layout.col_high_w);
      result.column_index = col_low | (col_high << layout.col_low_w);
   end

endmodule

// ===== design/memory_address_field_mapper.sv =====
// Memory address field mapper: splits each 64-bit physical address into vault,
// bank, bankgroup, row and column indices by slicing bit fields upward from the
// low end, in the order the mapping mode register selects. One address is taken
// per cycle while req_tready is high. There is an input register and then a result
// register, with the field slicing between them; the result register drives rsp.
// While a result waits, one more address is taken if the input register is empty.
// After that req_tready stays low until rsp_tready frees the result register.
// Configuration registers are written through the csr port; the user must write
// them only while idle, as the block itself does not enforce it.

module memory_address_field_mapper (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [mafm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mafm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // address requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [mafm_pkg::ADDR_W-1:0]          req_tdata,   // phys_address
   // mapped fields
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // vault_index, bank_index, bankgroup_index, row_index, column_index, zero fill
   output logic [mafm_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   mafm_pkg::cfg_type    cfg;
   mafm_pkg::layout_type layout;
   mafm_pkg::result_type result;

   logic                          addr_valid_ff, addr_valid_in;
   logic [mafm_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   mafm_pkg::result_type          rsp_ff, rsp_in;
   logic                          rsp_free;
   logic                          addr_free;

   mafm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mafm_layout u_layout (
      .cfg    (cfg),
      .layout (layout)
   );

   mafm_slice u_slice (
      .phys_address (addr_ff),
      .cfg          (cfg),
      .layout       (layout),
      .result       (result)
   );

   // each stage moves when the one after it is empty or draining
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign addr_free = !addr_valid_ff || rsp_free;

   always_comb begin
      addr_valid_in = addr_valid_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (rsp_free) begin
         rsp_valid_in = addr_valid_ff;
         rsp_in       = result;
      end
      if (addr_free) begin
         addr_valid_in = req_tvalid;
         addr_in       = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         addr_valid_ff <= addr_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign req_tready = addr_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mafm_pkg::RSP_DATA_W - mafm_pkg::RESULT_W){1'b0}}, rsp_ff};

endmodule

// ===== design/mafm_checker.sv =====
// mafm_checker: port-level checks on the address field mapper
// depends on mafm_pkg for widths; bound to memory_address_field_mapper below

module mafm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mafm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // coming out of reset both stages are empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_tready && !rsp_tvalid)
      else $error("pipeline not empty after reset");

   // the input side only stalls when a result is being held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without a pending result");

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // fill bits above the packed fields stay zero
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         rsp_tdata[mafm_pkg::RSP_DATA_W-1:mafm_pkg::RESULT_W] == '0)
      else $error("result fill bits set");

endmodule

bind memory_address_field_mapper mafm_checker u_mafm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
